// ===== rtl/core/bss_pkg.sv =====
// bss_pkg: shared types, codes and constants for the brush segment stamp core.
// Used by the register block, the arithmetic units and the top level.
package bss_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_NUM_LAYERS = 3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int MUL_W      = 34;
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 36;
   localparam int DIV_REM_W  = 38;
   localparam int DIV_CNT_W  = 7;

   localparam logic [DIV_CNT_W-1:0] STEPS_QUOT = 7'd64;
   localparam logic [DIV_CNT_W-1:0] STEPS_SQRT = 7'd18;
   localparam logic [DIV_CNT_W-1:0] STEPS_FALL = 7'd34;

   typedef enum logic [1:0] {
      KIND_BEGIN   = 2'd0,
      KIND_SEGMENT = 2'd1,
      KIND_READ    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REG_CANVAS_WIDTH  = 3'd0,
      REG_CANVAS_HEIGHT = 3'd1,
      REG_BRUSH_RADIUS  = 3'd2,
      REG_BRUSH_FLOW    = 3'd3,
      REG_DWELL_DECAY   = 3'd4,
      REG_ACTIVE_LAYER  = 3'd5
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BEGIN,
      ST_READ,
      ST_READ_WAIT,
      ST_SET_DX,
      ST_SET_DY,
      ST_SET_LEN,
      ST_SET_R2,
      ST_PIX,
      ST_DOT_A,
      ST_DOT_B,
      ST_DOT_C,
      ST_DIST_A,
      ST_DIST_B,
      ST_DIST_C,
      ST_CROSS_A,
      ST_CROSS_B,
      ST_CROSS_C,
      ST_CROSS_SQ,
      ST_CROSS_DIV,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_SQRT_WAIT,
      ST_FALL_WAIT,
      ST_FALL_SQ,
      ST_COV,
      ST_DECAY,
      ST_UPDATE,
      ST_NEXT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [8:0]  canvas_width;
      logic [8:0]  canvas_height;
      logic [9:0]  brush_radius;
      logic [15:0] brush_flow;
      logic [15:0] dwell_decay;
      logic [1:0]  active_layer;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic                 is_sqrt;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      logic [DIV_CNT_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] result;
   } div_res_type;

endpackage

// ===== rtl/core/bss_if.sv =====
// bss_if: item channels of the brush segment stamp core (request and response).
// Does not import or depend on bss_pkg.
interface bss_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [16:0] from_x;
   logic signed [16:0] from_y;
   logic signed [16:0] to_x;
   logic signed [16:0] to_y;
   logic               erase;
   logic               rearm;
   logic [7:0]         read_x;
   logic [7:0]         read_y;

   modport source (output valid, kind, from_x, from_y, to_x, to_y, erase, rearm, read_x,
                   read_y, input ready);
   modport sink (input valid, kind, from_x, from_y, to_x, to_y, erase, rearm, read_x,
                 read_y, output ready);
endinterface

interface bss_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] density_value;
   logic [16:0] changed_count;

   modport source (output valid, density_value, changed_count, input ready);
   modport sink (input valid, density_value, changed_count, output ready);
endinterface

// ===== rtl/core/brush_segment_stamp_core.sv =====
// brush_segment_stamp_core: paints capsule brush segments into per-layer density maps.
// Read item: reads the density map of the active layer. Begin item: mask sweep.
// Segment item: setup, then per box pixel an end-point distance check or, in the
// perpendicular case, a divide, a square root and a falloff.
// Reset: synchronous; afterwards a clearing pass zeroes the density and mask memories;
// no item is accepted meanwhile.
module brush_segment_stamp_core #(
   parameter int MAX_WIDTH  = bss_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bss_pkg::DEF_MAX_HEIGHT,
   parameter int NUM_LAYERS = bss_pkg::DEF_NUM_LAYERS
) (
   input  logic                            clock,
   input  logic                            reset,
   bss_req_if.sink                         req_ch,
   bss_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bss_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bss_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import bss_pkg::*;

   localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int MAW        = XW + YW;
   localparam int DENS_DEPTH = NUM_LAYERS * (2 ** MAW);
   localparam int DAW        = $clog2(DENS_DEPTH);
   localparam int MAW_DEPTH  = 2 ** MAW;

   cfg_type     cfg;
   div_cmd_type dcmd;
   div_res_type dres;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod;

   bss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   bss_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   bss_divsqrt u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .res   (dres)
   );

   assign csr_pready = 1'b1;

   // control
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      erase_ff, erase_in;
   logic [DAW-1:0] clr_ff, clr_in;

   // item and working registers
   logic [1:0]         kind_ff, kind_in;
   logic signed [16:0] fx_ff, fy_ff, tx_ff, ty_ff;
   logic signed [16:0] fx_in, fy_in, tx_in, ty_in;
   logic               rearm_ff, rearm_in;
   logic [7:0]         rx_ff, ry_ff, rx_in, ry_in;
   logic signed [19:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [XW-1:0]      x0_ff, x1_ff, x_ff, x0_in, x1_in, x_in;
   logic [YW-1:0]      y0_ff, y1_ff, y_ff, y0_in, y1_in, y_in;
   logic               empty_ff, empty_in;
   logic [35:0]        len2_ff, len2_in;
   logic [19:0]        r2_ff, r2_in;
   logic signed [19:0] px_ff, py_ff, px_in, py_in;
   logic signed [19:0] ex_ff, ey_ff, ex_in, ey_in;
   logic signed [39:0] acc_ff, acc_in;
   logic [32:0]        ac_ff, ac_in;
   logic [63:0]        d2_ff, d2_in;
   logic [15:0]        cov_ff, cov_in;
   logic [15:0]        m_ff, m_in;
   logic [16:0]        cnt_ff, cnt_in;
   logic [15:0]        dval_ff, dval_in;
   logic [16:0]        rcnt_ff, rcnt_in;

   // memories
   logic [15:0] dens_mem [DENS_DEPTH];
   logic [15:0] mask_mem [MAW_DEPTH];
   logic [15:0] dens_rd_ff, mask_rd_ff;
   logic [DAW-1:0] dens_ra, dens_wa;
   logic [MAW-1:0] mask_ra, mask_wa;
   logic [15:0]    dens_wd, mask_wd;
   logic           dens_we, mask_we;

   // derived combinational values
   logic [13:0]        ew, eh;
   logic [3:0]         layer_eff;
   logic               accept, rsp_free;
   logic [MAW-1:0]     pix_idx, rd_idx;
   logic signed [19:0] rad_s, lo_x, hi_x, lo_y, hi_y;
   logic signed [19:0] x0f, x1c, y0f, y1c, x0c, x1l, y0c, y1l, wm1, hm1;
   logic signed [19:0] dx_c, dy_c, px_c, py_c;
   logic signed [39:0] sum_c, diff_c, ac_c;
   logic [17:0]        rq, sq;
   logic [16:0]        cov17, vsum;
   logic [15:0]        m_eff, delta;

   always_comb begin
      ew        = (14'(cfg.canvas_width) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH)
                                                            : 14'(cfg.canvas_width);
      eh        = (14'(cfg.canvas_height) > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT)
                                                             : 14'(cfg.canvas_height);
      layer_eff = (4'(cfg.active_layer) >= 4'(NUM_LAYERS)) ? 4'(NUM_LAYERS - 1)
                                                           : 4'(cfg.active_layer);
   end

   assign accept   = req_ch.valid & req_ch.ready;
   assign rsp_free = ~rsp_valid_ff | rsp_ch.ready;
   assign pix_idx  = {y_ff, x_ff};
   assign rd_idx   = {YW'(ry_ff), XW'(rx_ff)};

   // bounding box
   assign rad_s = 20'($signed({1'b0, cfg.brush_radius}));
   assign lo_x  = 20'((fx_ff < tx_ff) ? fx_ff : tx_ff) - rad_s - 20'sd16;
   assign hi_x  = 20'((fx_ff > tx_ff) ? fx_ff : tx_ff) + rad_s + 20'sd31;
   assign lo_y  = 20'((fy_ff < ty_ff) ? fy_ff : ty_ff) - rad_s - 20'sd16;
   assign hi_y  = 20'((fy_ff > ty_ff) ? fy_ff : ty_ff) + rad_s + 20'sd31;
   assign x0f   = lo_x >>> 4;
   assign x1c   = hi_x >>> 4;
   assign y0f   = lo_y >>> 4;
   assign y1c   = hi_y >>> 4;
   assign wm1   = 20'($signed({1'b0, ew})) - 20'sd1;
   assign hm1   = 20'($signed({1'b0, eh})) - 20'sd1;
   assign x0c   = (x0f < 20'sd0) ? 20'sd0 : x0f;
   assign y0c   = (y0f < 20'sd0) ? 20'sd0 : y0f;
   assign x1l   = (x1c > wm1) ? wm1 : x1c;
   assign y1l   = (y1c > hm1) ? hm1 : y1c;

   assign dx_c  = 20'(tx_ff) - 20'(fx_ff);
   assign dy_c  = 20'(ty_ff) - 20'(fy_ff);
   assign px_c  = 20'($signed({1'b0, x_ff, 4'b0000})) - 20'(fx_ff);
   assign py_c  = 20'($signed({1'b0, y_ff, 4'b0000})) - 20'(fy_ff);

   assign sum_c  = acc_ff + 40'(prod);
   assign diff_c = acc_ff - 40'(prod);
   assign ac_c   = (diff_c < 40'sd0) ? -diff_c : diff_c;

   assign rq    = {cfg.brush_radius, 8'h00};
   assign sq    = dres.result[17:0];
   assign cov17 = prod[32:16];
   assign m_eff = rearm_ff ? prod[31:16] : m_ff;
   assign delta = prod[31:16];
   assign vsum  = 17'(dens_rd_ff) + 17'(delta);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      erase_in     = erase_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      rearm_in     = rearm_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      empty_in     = empty_ff;
      len2_in      = len2_ff;
      r2_in        = r2_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      acc_in       = acc_ff;
      ac_in        = ac_ff;
      d2_in        = d2_ff;
      cov_in       = cov_ff;
      m_in         = m_ff;
      cnt_in       = cnt_ff;
      dval_in      = dval_ff;
      rcnt_in      = rcnt_ff;
      mul_a        = '0;
      mul_b        = '0;
      dcmd         = '0;
      dens_ra      = DAW'({layer_eff, pix_idx});
      mask_ra      = pix_idx;
      dens_we      = 1'b0;
      dens_wa      = DAW'({layer_eff, pix_idx});
      dens_wd      = '0;
      mask_we      = 1'b0;
      mask_wa      = pix_idx;
      mask_wd      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            dens_we = 1'b1;
            dens_wa = clr_ff;
            mask_we = 1'b1;
            mask_wa = clr_ff[MAW-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == DAW'(DENS_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_ch.kind;
               fx_in    = req_ch.from_x;
               fy_in    = req_ch.from_y;
               tx_in    = req_ch.to_x;
               ty_in    = req_ch.to_y;
               rearm_in = req_ch.rearm;
               rx_in    = req_ch.read_x;
               ry_in    = req_ch.read_y;
               dval_in  = '0;
               rcnt_in  = '0;
               clr_in   = '0;
               unique case (kind_type'(req_ch.kind))
                  KIND_BEGIN: begin
                     erase_in = req_ch.erase;
                     state_in = ST_BEGIN;
                  end
                  KIND_SEGMENT: state_in = ST_SET_DX;
                  KIND_READ:    state_in = ST_READ;
                  default:      state_in = ST_FINISH;
               endcase
            end
         end
         ST_BEGIN: begin
            mask_we = 1'b1;
            mask_wa = clr_ff[MAW-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff[MAW-1:0] == '1) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            dens_ra  = DAW'({layer_eff, rd_idx});
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            if (14'(rx_ff) < ew && 14'(ry_ff) < eh) begin
               dval_in = dens_rd_ff;
            end
            state_in = ST_FINISH;
         end
         ST_SET_DX: begin
            dx_in    = dx_c;
            dy_in    = dy_c;
            x0_in    = XW'(x0c);
            x1_in    = XW'(x1l);
            y0_in    = YW'(y0c);
            y1_in    = YW'(y1l);
            empty_in = (x1l < x0c) || (y1l < y0c) || (cfg.brush_radius == '0)
                       || (ew == '0) || (eh == '0);
            mul_a    = MUL_W'(dx_c);
            mul_b    = MUL_W'(dx_c);
            state_in = ST_SET_DY;
         end
         ST_SET_DY: begin
            acc_in   = 40'(prod);
            mul_a    = MUL_W'(dy_ff);
            mul_b    = MUL_W'(dy_ff);
            state_in = ST_SET_LEN;
         end
         ST_SET_LEN: begin
            len2_in  = 36'(sum_c);
            mul_a    = MUL_W'($signed({1'b0, cfg.brush_radius}));
            mul_b    = MUL_W'($signed({1'b0, cfg.brush_radius}));
            state_in = ST_SET_R2;
         end
         ST_SET_R2: begin
            r2_in  = prod[19:0];
            cnt_in = '0;
            x_in   = x0_ff;
            y_in   = y0_ff;
            if (empty_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PIX;
            end
         end
         ST_PIX: begin
            px_in    = px_c;
            py_in    = py_c;
            state_in = ST_DOT_A;
         end
         ST_DOT_A: begin
            mul_a    = MUL_W'(px_ff);
            mul_b    = MUL_W'(dx_ff);
            state_in = ST_DOT_B;
         end
         ST_DOT_B: begin
            acc_in   = 40'(prod);
            mul_a    = MUL_W'(py_ff);
            mul_b    = MUL_W'(dy_ff);
            state_in = ST_DOT_C;
         end
         ST_DOT_C: begin
            if (sum_c <= 40'sd0) begin
               ex_in    = px_ff;
               ey_in    = py_ff;
               state_in = ST_DIST_A;
            end else if (sum_c >= 40'($signed({1'b0, len2_ff}))) begin
               ex_in    = px_ff - dx_ff;
               ey_in    = py_ff - dy_ff;
               state_in = ST_DIST_A;
            end else begin
               state_in = ST_CROSS_A;
            end
         end
         ST_DIST_A: begin
            mul_a    = MUL_W'(ex_ff);
            mul_b    = MUL_W'(ex_ff);
            state_in = ST_DIST_B;
         end
         ST_DIST_B: begin
            acc_in   = 40'(prod);
            mul_a    = MUL_W'(ey_ff);
            mul_b    = MUL_W'(ey_ff);
            state_in = ST_DIST_C;
         end
         ST_DIST_C: begin
            d2_in    = 64'($unsigned(sum_c));
            state_in = ST_CHECK;
         end
         ST_CROSS_A: begin
            mul_a    = MUL_W'(px_ff);
            mul_b    = MUL_W'(dy_ff);
            state_in = ST_CROSS_B;
         end
         ST_CROSS_B: begin
            acc_in   = 40'(prod);
            mul_a    = MUL_W'(py_ff);
            mul_b    = MUL_W'(dx_ff);
            state_in = ST_CROSS_C;
         end
         ST_CROSS_C: begin
            ac_in = 33'($unsigned(ac_c));
            if (ac_c[39:32] != '0) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_CROSS_SQ;
            end
         end
         ST_CROSS_SQ: begin
            mul_a    = MUL_W'($signed({1'b0, ac_ff}));
            mul_b    = MUL_W'($signed({1'b0, ac_ff}));
            state_in = ST_CROSS_DIV;
         end
         ST_CROSS_DIV: begin
            dcmd.start   = 1'b1;
            dcmd.is_sqrt = 1'b0;
            dcmd.num     = prod[63:0];
            dcmd.den     = len2_ff;
            dcmd.steps   = STEPS_QUOT;
            state_in     = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (dres.done) begin
               d2_in    = dres.result;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (d2_ff >= 64'(r2_ff)) begin
               state_in = ST_NEXT;
            end else begin
               dcmd.start   = 1'b1;
               dcmd.is_sqrt = 1'b1;
               dcmd.num     = {d2_ff[19:0], 16'h0000, 28'h0};
               dcmd.den     = '0;
               dcmd.steps   = STEPS_SQRT;
               state_in     = ST_SQRT_WAIT;
            end
         end
         ST_SQRT_WAIT: begin
            if (dres.done) begin
               if (sq >= rq) begin
                  state_in = ST_NEXT;
               end else begin
                  dcmd.start   = 1'b1;
                  dcmd.is_sqrt = 1'b0;
                  dcmd.num     = {rq - sq, 16'h0000, 30'h0};
                  dcmd.den     = 36'(rq);
                  dcmd.steps   = STEPS_FALL;
                  state_in     = ST_FALL_WAIT;
               end
            end
         end
         ST_FALL_WAIT: begin
            if (dres.done) begin
               state_in = ST_FALL_SQ;
            end
         end
         ST_FALL_SQ: begin
            mul_a    = MUL_W'($signed({1'b0, dres.result[16:0]}));
            mul_b    = MUL_W'($signed({1'b0, dres.result[16:0]}));
            state_in = ST_COV;
         end
         ST_COV: begin
            cov_in   = cov17[16] ? 16'hFFFF : cov17[15:0];
            m_in     = mask_rd_ff;
            mul_a    = MUL_W'($signed({1'b0, mask_rd_ff}));
            mul_b    = MUL_W'($signed({1'b0, 17'h10000 - 17'(cfg.dwell_decay)}));
            state_in = ST_DECAY;
         end
         ST_DECAY: begin
            if (cov_ff > m_eff) begin
               mask_we  = 1'b1;
               mask_wd  = cov_ff;
               mul_a    = MUL_W'($signed({1'b0, cfg.brush_flow}));
               mul_b    = MUL_W'($signed({1'b0, cov_ff - m_eff}));
               state_in = ST_UPDATE;
            end else begin
               mask_we  = rearm_ff;
               mask_wd  = m_eff;
               state_in = ST_NEXT;
            end
         end
         ST_UPDATE: begin
            dens_we = 1'b1;
            if (erase_ff) begin
               dens_wd = (dens_rd_ff < delta) ? 16'h0000 : dens_rd_ff - delta;
            end else begin
               dens_wd = vsum[16] ? 16'hFFFF : vsum[15:0];
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (x_ff == x1_ff) begin
               x_in = x0_ff;
               if (y_ff == y1_ff) begin
                  rcnt_in  = cnt_ff;
                  state_in = ST_FINISH;
               end else begin
                  y_in     = y_ff + 1'b1;
                  state_in = ST_PIX;
               end
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = ST_PIX;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;

   logic [15:0] out_dval_ff;
   logic [16:0] out_cnt_ff;
   assign rsp_ch.density_value = out_dval_ff;
   assign rsp_ch.changed_count = out_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         erase_ff     <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         erase_ff     <= erase_in;
         clr_ff       <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      rearm_ff <= rearm_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      y0_ff    <= y0_in;
      y1_ff    <= y1_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      empty_ff <= empty_in;
      len2_ff  <= len2_in;
      r2_ff    <= r2_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      acc_ff   <= acc_in;
      ac_ff    <= ac_in;
      d2_ff    <= d2_in;
      cov_ff   <= cov_in;
      m_ff     <= m_in;
      cnt_ff   <= cnt_in;
      dval_ff  <= dval_in;
      rcnt_ff  <= rcnt_in;
      if (state_ff == ST_FINISH && rsp_free) begin
         out_dval_ff <= dval_ff;
         out_cnt_ff  <= (kind_type'(kind_ff) == KIND_SEGMENT) ? rcnt_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (dens_we) begin
         dens_mem[dens_wa] <= dens_wd;
      end
      dens_rd_ff <= dens_mem[dens_ra];
   end

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_wa] <= mask_wd;
      end
      mask_rd_ff <= mask_mem[mask_ra];
   end

   // checks
   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ch.ready)
      else $error("item accepted during clearing pass");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      dcmd.start |-> !dres.busy)
      else $error("divide/sqrt unit restarted while busy");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_dens_write_update: assert property (@(posedge clock) disable iff (reset)
      dens_we |-> (state_ff == ST_UPDATE || state_ff == ST_CLEAR))
      else $error("density written outside update or clear");

endmodule

// ===== rtl/core/bss_csr.sv =====
// bss_csr: APB-style configuration registers of the brush segment stamp core.
// Depends on bss_pkg (cfg_type, register indexes).
module bss_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bss_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bss_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bss_pkg::CSR_DATA_W-1:0]    prdata,
   output bss_pkg::cfg_type                  cfg
);
   import bss_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(paddr[4:2]);
   assign wr  = psel & penable & pwrite;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_CANVAS_WIDTH:  cfg_in.canvas_width  = pwdata[8:0];
            REG_CANVAS_HEIGHT: cfg_in.canvas_height = pwdata[8:0];
            REG_BRUSH_RADIUS:  cfg_in.brush_radius  = pwdata[9:0];
            REG_BRUSH_FLOW:    cfg_in.brush_flow    = pwdata[15:0];
            REG_DWELL_DECAY:   cfg_in.dwell_decay   = pwdata[15:0];
            REG_ACTIVE_LAYER:  cfg_in.active_layer  = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CANVAS_WIDTH:  prdata = 32'(cfg_ff.canvas_width);
         REG_CANVAS_HEIGHT: prdata = 32'(cfg_ff.canvas_height);
         REG_BRUSH_RADIUS:  prdata = 32'(cfg_ff.brush_radius);
         REG_BRUSH_FLOW:    prdata = 32'(cfg_ff.brush_flow);
         REG_DWELL_DECAY:   prdata = 32'(cfg_ff.dwell_decay);
         REG_ACTIVE_LAYER:  prdata = 32'(cfg_ff.active_layer);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_width  <= 9'd256;
         cfg_ff.canvas_height <= 9'd256;
         cfg_ff.brush_radius  <= 10'd160;
         cfg_ff.brush_flow    <= 16'd32768;
         cfg_ff.dwell_decay   <= 16'd6554;
         cfg_ff.active_layer  <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/bss_mul.sv =====
// bss_mul: shared signed multiplier with registered product.
// Depends on bss_pkg (MUL_W).
module bss_mul (
   input  logic                                clock,
   input  logic signed [bss_pkg::MUL_W-1:0]    op_a,
   input  logic signed [bss_pkg::MUL_W-1:0]    op_b,
   output logic signed [2*bss_pkg::MUL_W-1:0]  prod_ff
);
   import bss_pkg::*;

   logic signed [2*MUL_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/core/bss_divsqrt.sv =====
// bss_divsqrt: shared bit-serial unit, restoring divide (one quotient bit a cycle)
// or integer square root (one root bit a cycle). Depends on bss_pkg.
module bss_divsqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  bss_pkg::div_cmd_type  cmd,
   output bss_pkg::div_res_type  res
);
   import bss_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 sqrt_ff, sqrt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_REM_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_REM_W-1:0] partial, trial;
   logic                 ge;

   assign partial = sqrt_ff ? {rem_ff[DIV_REM_W-3:0], num_ff[DIV_NUM_W-1 -: 2]}
                            : {rem_ff[DIV_REM_W-2:0], num_ff[DIV_NUM_W-1]};
   assign trial   = sqrt_ff ? {quo_ff[DIV_REM_W-3:0], 2'b01}
                            : DIV_REM_W'(den_ff);
   assign ge      = partial >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         sqrt_in = cmd.is_sqrt;
         num_in  = cmd.num;
         den_in  = cmd.den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = cmd.steps;
      end else if (busy_ff) begin
         rem_in = ge ? partial - trial : partial;
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         num_in = sqrt_ff ? {num_ff[DIV_NUM_W-3:0], 2'b00} : {num_ff[DIV_NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sqrt_ff <= sqrt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   assign res.busy   = busy_ff;
   assign res.done   = done_ff;
   assign res.result = quo_ff;

endmodule
